### rtl/fixed_point_q24_8_alu_assert.svh
// assertion macros for the alu back end (fxa_back)
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// check a property on every rising clock edge outside reset
`define FXA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on the next clock edge
`define FXA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fxa_pkg.sv
package fxa_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MIN  = 4'd4,
    OP_MAX  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_CMP  = 4'd8,
    OP_TINT = 4'd9,
    OP_FINT = 4'd10,
    OP_NONE = 4'd15
  } op_e;

  localparam logic signed [31:0] RAW_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] RAW_MIN = 32'sh80000000;

  // classified item handed from the front end to the back end
  typedef struct packed {
    op_e                op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               is_less;
    logic               is_greater;
    logic               is_equal;
    logic               divide_by_zero;
    logic               saturated;
  } res_t;

endpackage

### rtl/fxa_front.sv
module fxa_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_stall_o,
  input  logic [3:0]       req_type_i,
  input  logic [31:0]      operand_a_i,
  input  logic [31:0]      operand_b_i,
  output logic             fq_valid_o,
  input  logic             fq_stall_i,
  output fxa_pkg::item_t   fq_item_o
);

  localparam int Depth = 2;

  fxa_pkg::item_t   mem_q [Depth];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  fxa_pkg::op_e     op;
  logic             push, pop;

  always_comb begin
    case (req_type_i)
      4'd0:    op = fxa_pkg::OP_ADD;
      4'd1:    op = fxa_pkg::OP_SUB;
      4'd2:    op = fxa_pkg::OP_MUL;
      4'd3:    op = fxa_pkg::OP_DIV;
      4'd4:    op = fxa_pkg::OP_MIN;
      4'd5:    op = fxa_pkg::OP_MAX;
      4'd6:    op = fxa_pkg::OP_INC;
      4'd7:    op = fxa_pkg::OP_DEC;
      4'd8:    op = fxa_pkg::OP_CMP;
      4'd9:    op = fxa_pkg::OP_TINT;
      4'd10:   op = fxa_pkg::OP_FINT;
      default: op = fxa_pkg::OP_NONE;
    endcase
  end

  assign req_stall_o = (cnt_q == 2'(Depth));
  assign push        = req_valid_i && !req_stall_o;
  assign fq_valid_o  = (cnt_q != 2'd0);
  assign pop         = fq_valid_o && !fq_stall_i;
  assign fq_item_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= '{op: op, a: operand_a_i, b: operand_b_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/fxa_div.sv
// pipelined restoring divider, one quotient bit per stage, unsigned
module fxa_div #(
  parameter int NumW = 49,
  parameter int DenW = 33,
  parameter int TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [NumW-1:0] quo_o,
  output logic [TagW-1:0] tag_o
);

  logic [NumW-1:0] n_q   [NumW+1];
  logic [DenW-1:0] r_q   [NumW+1];
  logic [DenW-1:0] d_q   [NumW+1];
  logic [TagW-1:0] t_q   [NumW+1];
  logic            v_q   [NumW+1];

  always_comb begin
    n_q[0] = num_i;
    r_q[0] = '0;
    d_q[0] = den_i;
    t_q[0] = tag_i;
    v_q[0] = valid_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW:0] trial;
    logic [DenW:0] diff;
    assign trial = {r_q[s], n_q[s][NumW-1]};
    assign diff  = trial - {1'b0, d_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s+1] <= {n_q[s][NumW-2:0], !diff[DenW]};
        r_q[s+1] <= diff[DenW] ? trial[DenW-1:0] : diff[DenW-1:0];
        d_q[s+1] <= d_q[s];
        t_q[s+1] <= t_q[s];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end
  end

  assign valid_o = v_q[NumW];
  assign quo_o   = n_q[NumW];
  assign tag_o   = t_q[NumW];

endmodule

### rtl/fxa_back.sv
module fxa_back #(
  parameter int FractionBits = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fq_valid_i,
  output logic            fq_stall_o,
  input  fxa_pkg::item_t  fq_item_i,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output fxa_pkg::res_t   res_o
);

  `include "fixed_point_q24_8_alu_assert.svh"

  localparam int NumW  = 2 * (32 + FractionBits) + 1;
  localparam int DenW  = 34;
  localparam int MulW  = 64;
  localparam int SumW  = 65;
  localparam int ResW  = $bits(fxa_pkg::res_t);
  localparam int TagW  = ResW + 2;

  // the pipe advances as a whole when the output slot is free or moves on
  logic en;
  assign en         = !res_valid_o || !res_stall_i;
  assign fq_stall_o = !en;

  // stage 1: simple ops finish here, mul product, div operand prep
  fxa_pkg::item_t     it;
  fxa_pkg::res_t      simple;
  logic signed [32:0] ext;
  logic [31:0]        ma, mb;
  logic               is_mul, is_div, neg_q;
  assign it = fq_item_i;

  always_comb begin
    logic signed [32:0] sa, sb;
    logic signed [63:0] sh;
    sa = {it.a[31], it.a};
    sb = {it.b[31], it.b};
    ext = '0;
    sh  = '0;
    simple = '0;
    case (it.op)
      fxa_pkg::OP_ADD: ext = sa + sb;
      fxa_pkg::OP_SUB: ext = sa - sb;
      fxa_pkg::OP_INC: ext = sa + 33'sd1;
      fxa_pkg::OP_DEC: ext = sa - 33'sd1;
      default:         ext = '0;
    endcase
    case (it.op)
      fxa_pkg::OP_ADD, fxa_pkg::OP_SUB, fxa_pkg::OP_INC, fxa_pkg::OP_DEC: begin
        if (ext > 33'sh0_7fffffff) begin
          simple.result = fxa_pkg::RAW_MAX; simple.saturated = 1'b1;
        end else if (ext < -33'sh0_80000000) begin
          simple.result = fxa_pkg::RAW_MIN; simple.saturated = 1'b1;
        end else begin
          simple.result = ext[31:0];
        end
      end
      fxa_pkg::OP_MIN: simple.result = (it.a > it.b) ? it.b : it.a;
      fxa_pkg::OP_MAX: simple.result = (it.a < it.b) ? it.b : it.a;
      fxa_pkg::OP_CMP: begin
        simple.is_less    = it.a < it.b;
        simple.is_greater = it.a > it.b;
        simple.is_equal   = it.a == it.b;
      end
      fxa_pkg::OP_TINT: begin
        // truncate the magnitude, then restore the sign
        simple.result = it.a[31] ? 32'(-(ma >> FractionBits)) : (ma >> FractionBits);
      end
      fxa_pkg::OP_FINT: begin
        sh = 64'(it.a) <<< FractionBits;
        if (sh > 64'sh7fffffff) begin
          simple.result = fxa_pkg::RAW_MAX; simple.saturated = 1'b1;
        end else if (sh < -64'sh80000000) begin
          simple.result = fxa_pkg::RAW_MIN; simple.saturated = 1'b1;
        end else begin
          simple.result = sh[31:0];
        end
      end
      fxa_pkg::OP_DIV: begin
        if (it.b == '0) begin
          simple.result = it.a[31] ? fxa_pkg::RAW_MIN : fxa_pkg::RAW_MAX;
          simple.divide_by_zero = 1'b1;
          simple.saturated = 1'b1;
        end
      end
      default: simple = '0;
    endcase
  end

  assign ma     = it.a[31] ? 32'(-it.a) : it.a;
  assign mb     = it.b[31] ? 32'(-it.b) : it.b;
  assign is_mul = fq_valid_i && (it.op == fxa_pkg::OP_MUL);
  assign is_div = fq_valid_i && (it.op == fxa_pkg::OP_DIV) && (it.b != '0);
  assign neg_q  = it.a[31] ^ it.b[31];

  // mul: one unsigned 32x32 product registered, then round, then align with divider
  logic            m1_v_q, m1_neg_q;
  logic [MulW-1:0] m1_p_q;
  logic            s1_v_q;
  fxa_pkg::res_t   s1_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_p_q   <= MulW'(ma) * MulW'(mb);
      m1_neg_q <= neg_q;
      s1_r_q   <= simple;
    end
  end

  // rounded multiply result (one wide add and a clamp)
  fxa_pkg::res_t mul_res;
  always_comb begin
    logic [SumW-1:0] m;
    m = ({1'b0, m1_p_q} + SumW'(1 << (FractionBits - 1))) >> FractionBits;
    mul_res = '0;
    if (!m1_neg_q) begin
      if (m > SumW'(32'h7fffffff)) begin
        mul_res.result = fxa_pkg::RAW_MAX; mul_res.saturated = 1'b1;
      end else begin
        mul_res.result = m[31:0];
      end
    end else begin
      if (m > SumW'(33'h080000000)) begin
        mul_res.result = fxa_pkg::RAW_MIN; mul_res.saturated = 1'b1;
      end else begin
        mul_res.result = 32'(-m[31:0]);
      end
    end
  end

  // divider: quotient of (2*|a|*2^F + |b|) / (2*|b|), fed from stage 2
  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  assign num = (NumW'(ma) << (FractionBits + 1)) + NumW'(mb);
  assign den = DenW'({mb, 1'b0});

  // every item travels down the divider pipe so that order holds
  logic [TagW-1:0] tag_in, tag_out;
  logic            dv_v;
  logic [NumW-1:0] quo;
  logic            mv_q;
  fxa_pkg::res_t   mr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= is_mul;
      s1_v_q <= fq_valid_i;
    end
  end

  // stage 2 carries the mul result or the simple result into the divider tag
  always_ff @(posedge clk_i) begin
    if (en) begin
      mr_q <= m1_v_q ? mul_res : s1_r_q;
    end
  end
  logic s2_v_q, s2_div_q, s2_neg_q;
  logic s1_div_q, s1_neg_q;
  logic [NumW-1:0] s1_num_q, s2_num_q;
  logic [DenW-1:0] s1_den_q, s2_den_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_div_q <= is_div;
      s1_neg_q <= neg_q;
      s1_num_q <= num;
      s1_den_q <= den;
      s2_div_q <= s1_div_q;
      s2_neg_q <= s1_neg_q;
      s2_num_q <= s1_num_q;
      s2_den_q <= s1_den_q;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end
  assign mv_q = s2_div_q;

  assign tag_in = {mv_q, s2_neg_q, mr_q};

  fxa_div #(.NumW(NumW), .DenW(DenW), .TagW(TagW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .num_i   (s2_num_q),
    .den_i   (s2_den_q),
    .tag_i   (tag_in),
    .valid_o (dv_v),
    .quo_o   (quo),
    .tag_o   (tag_out)
  );

  // final clamp and sign of the quotient, then the output register
  fxa_pkg::res_t fin;
  always_comb begin
    fin = tag_out[ResW-1:0];
    if (tag_out[TagW-1]) begin
      fin = '0;
      if (!tag_out[TagW-2]) begin
        if (quo > NumW'(32'h7fffffff)) begin
          fin.result = fxa_pkg::RAW_MAX; fin.saturated = 1'b1;
        end else begin
          fin.result = quo[31:0];
        end
      end else begin
        if (quo > NumW'(33'h080000000)) begin
          fin.result = fxa_pkg::RAW_MIN; fin.saturated = 1'b1;
        end else begin
          fin.result = 32'(-quo[31:0]);
        end
      end
    end
  end

  logic          out_v_q;
  fxa_pkg::res_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= fin;
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  `FXA_ASSERT(a_flag_onehot, !res_valid_o || $onehot0({res_o.is_less, res_o.is_greater,
    res_o.is_equal}), "compare flags not exclusive")
  `FXA_ASSERT(a_dz_sat, !res_valid_o || !res_o.divide_by_zero || res_o.saturated,
    "divide by zero without saturation")
  `FXA_ASSERT_NEXT(a_hold, res_valid_o && res_stall_i, res_valid_o && $stable(res_o),
    "result moved while stalled")

endmodule

### rtl/fixed_point_q24_8_alu.sv
// Signed Q24.8 fixed-point ALU. One operation enters per cycle when the input
// is not stalled, and one result leaves per operation, in order. A two-entry
// queue separates the input side from the execution pipe; every operation runs
// through the same pipe, whose length is set by the pipelined divider (one
// stage per quotient bit). Multiply and divide round to nearest, ties away from
// zero; results out of range saturate.
module fixed_point_q24_8_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         req_type_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_o,
  output logic               is_less_o,
  output logic               is_greater_o,
  output logic               is_equal_o,
  output logic               divide_by_zero_o,
  output logic               saturated_o
);

  logic           fq_valid, fq_stall;
  fxa_pkg::item_t fq_item;
  fxa_pkg::res_t  res;

  fxa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .req_type_i  (req_type_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .fq_valid_o  (fq_valid),
    .fq_stall_i  (fq_stall),
    .fq_item_o   (fq_item)
  );

  fxa_back #(.FractionBits(FRACTION_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fq_valid_i  (fq_valid),
    .fq_stall_o  (fq_stall),
    .fq_item_i   (fq_item),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign result_o         = res.result;
  assign is_less_o        = res.is_less;
  assign is_greater_o     = res.is_greater;
  assign is_equal_o       = res.is_equal;
  assign divide_by_zero_o = res.divide_by_zero;
  assign saturated_o      = res.saturated;

endmodule

### tb/fixed_point_q24_8_alu_test.sv
module fixed_point_q24_8_alu_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam int PIPE_DEPTH = 2 * (32 + FRAC) + 4;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [31:0] result;
    logic               is_less;
    logic               is_greater;
    logic               is_equal;
    logic               divide_by_zero;
    logic               saturated;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending[$];
    int       errors;

    function logic signed [31:0] clamp(input logic signed [65:0] v, inout logic sat);
      if (v > 66'sd2147483647) begin
        sat = 1'b1;
        return fxa_pkg::RAW_MAX;
      end
      if (v < -66'sd2147483648) begin
        sat = 1'b1;
        return fxa_pkg::RAW_MIN;
      end
      return v[31:0];
    endfunction

    function alu_res_t compute(input logic [3:0] op, input logic signed [31:0] a,
                               input logic signed [31:0] b);
      alu_res_t r;
      logic signed [65:0] wa, wb, p, s;
      logic [65:0] m, q, na, nb;
      logic neg;
      r = '0;
      wa = a;
      wb = b;
      case (op)
        fxa_pkg::OP_ADD: r.result = clamp(wa + wb, r.saturated);
        fxa_pkg::OP_SUB: r.result = clamp(wa - wb, r.saturated);
        fxa_pkg::OP_MUL: begin
          p = wa * wb;
          m = p < 0 ? -p : p;
          m = (m + (66'd1 << (FRAC - 1))) >> FRAC;
          s = p < 0 ? -$signed(m) : $signed(m);
          r.result = clamp(s, r.saturated);
        end
        fxa_pkg::OP_DIV: begin
          if (b == 0) begin
            r.divide_by_zero = 1'b1;
            r.saturated = 1'b1;
            r.result = a < 0 ? fxa_pkg::RAW_MIN : fxa_pkg::RAW_MAX;
          end else begin
            na = (wa < 0 ? -wa : wa) << FRAC;
            nb = wb < 0 ? -wb : wb;
            q = (2 * na + nb) / (2 * nb);
            neg = (a < 0) != (b < 0);
            s = neg ? -$signed(q) : $signed(q);
            r.result = clamp(s, r.saturated);
          end
        end
        fxa_pkg::OP_MIN: r.result = a > b ? b : a;
        fxa_pkg::OP_MAX: r.result = a < b ? b : a;
        fxa_pkg::OP_INC: r.result = clamp(wa + 1, r.saturated);
        fxa_pkg::OP_DEC: r.result = clamp(wa - 1, r.saturated);
        fxa_pkg::OP_CMP: begin
          r.is_less = a < b;
          r.is_greater = a > b;
          r.is_equal = a == b;
        end
        fxa_pkg::OP_TINT: begin
          m = (wa < 0 ? -wa : wa) >> FRAC;
          s = a < 0 ? -$signed(m) : $signed(m);
          r.result = s[31:0];
        end
        fxa_pkg::OP_FINT: r.result = clamp(wa * (66'sd1 <<< FRAC), r.saturated);
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_operation(input logic [3:0] op, input logic signed [31:0] a,
                                 input logic signed [31:0] b);
      pending.push_back(compute(op, a, b));
    endfunction

    function void check_result(input alu_res_t got);
      alu_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result !== want.result) begin
        $display("%0t: result expected %h actual %h", $time, want.result, got.result);
        errors++;
      end
      if (got.is_less !== want.is_less) begin
        $display("%0t: is_less expected %b actual %b", $time, want.is_less, got.is_less);
        errors++;
      end
      if (got.is_greater !== want.is_greater) begin
        $display("%0t: is_greater expected %b actual %b", $time, want.is_greater,
                 got.is_greater);
        errors++;
      end
      if (got.is_equal !== want.is_equal) begin
        $display("%0t: is_equal expected %b actual %b", $time, want.is_equal, got.is_equal);
        errors++;
      end
      if (got.divide_by_zero !== want.divide_by_zero) begin
        $display("%0t: divide_by_zero expected %b actual %b", $time, want.divide_by_zero,
                 got.divide_by_zero);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                 got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [3:0]         req_type_i;
  logic signed [31:0] operand_a_i;
  logic signed [31:0] operand_b_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] result_o;
  logic               is_less_o;
  logic               is_greater_o;
  logic               is_equal_o;
  logic               divide_by_zero_o;
  logic               saturated_o;

  alu_scoreboard board;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            cycles;

  fixed_point_q24_8_alu dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_o         (result_o),
    .is_less_o        (is_less_o),
    .is_greater_o     (is_greater_o),
    .is_equal_o       (is_equal_o),
    .divide_by_zero_o (divide_by_zero_o),
    .saturated_o      (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: stall at random and check every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_result({result_o, is_less_o, is_greater_o, is_equal_o,
                            divide_by_zero_o, saturated_o});
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // drive one beat, holding it until accepted
  task automatic send_op(input logic [3:0] op, input logic signed [31:0] a,
                         input logic signed [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    board.note_operation(op, a, b);
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(7))
      0: return fxa_pkg::RAW_MAX - $urandom_range(3);
      1: return fxa_pkg::RAW_MIN + $urandom_range(3);
      2: return $signed($urandom_range(1023)) - 512;
      3: return 32'sd0;
      4: return $signed($urandom_range(65535)) << $urandom_range(16);
      5: return ($signed($urandom_range(255)) - 128) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int count);
    logic [3:0]         op;
    logic signed [31:0] a, b;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10));
      a = pick_operand();
      b = pick_operand();
      send_op(op, a, b);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    board = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    req_type_i = '0;
    operand_a_i = '0;
    operand_b_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(fxa_pkg::OP_ADD, fxa_pkg::RAW_MAX, 32'sd1);
    send_op(fxa_pkg::OP_SUB, fxa_pkg::RAW_MIN, 32'sd1);
    send_op(fxa_pkg::OP_MUL, fxa_pkg::RAW_MAX, fxa_pkg::RAW_MAX);
    send_op(fxa_pkg::OP_MUL, -32'sd384, 32'sd128);
    send_op(fxa_pkg::OP_MUL, fxa_pkg::RAW_MIN, fxa_pkg::RAW_MIN);
    send_op(fxa_pkg::OP_DIV, 32'sd256, 32'sd0);
    send_op(fxa_pkg::OP_DIV, -32'sd256, 32'sd0);
    send_op(fxa_pkg::OP_DIV, fxa_pkg::RAW_MIN, -32'sd1);
    send_op(fxa_pkg::OP_DIV, -32'sd1, 32'sd512);
    send_op(fxa_pkg::OP_MIN, 32'sd77, 32'sd77);
    send_op(fxa_pkg::OP_MAX, fxa_pkg::RAW_MIN, fxa_pkg::RAW_MAX);
    send_op(fxa_pkg::OP_MIN, fxa_pkg::RAW_MIN, fxa_pkg::RAW_MAX);
    send_op(fxa_pkg::OP_INC, fxa_pkg::RAW_MAX, 32'sd0);
    send_op(fxa_pkg::OP_DEC, fxa_pkg::RAW_MIN, 32'sd0);
    send_op(fxa_pkg::OP_CMP, 32'sd5, 32'sd5);
    send_op(fxa_pkg::OP_CMP, fxa_pkg::RAW_MIN, fxa_pkg::RAW_MAX);
    send_op(fxa_pkg::OP_CMP, fxa_pkg::RAW_MAX, fxa_pkg::RAW_MIN);
    send_op(fxa_pkg::OP_TINT, -32'sd257, 32'sd0);
    send_op(fxa_pkg::OP_TINT, fxa_pkg::RAW_MIN, fxa_pkg::RAW_MAX);
    send_op(fxa_pkg::OP_FINT, 32'sd8388608, 32'sd0);
    send_op(fxa_pkg::OP_FINT, -32'sd8388609, 32'sd0);
    send_op(fxa_pkg::OP_FINT, -32'sd8388608, -32'sd1);
    send_op(4'd11, fxa_pkg::RAW_MAX, fxa_pkg::RAW_MIN);
    send_op(fxa_pkg::OP_NONE, -32'sd1, -32'sd1);

    // hold off until the pipe has emptied
    wait_drained();

    send_idle_pct = 26;
    recv_idle_pct = 86;
    run_random(500);
    send_idle_pct = 86;
    recv_idle_pct = 26;
    run_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(750);

    wait_drained();
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
